>>> src/swmm_pkg.sv
// Package for the sliding window min/max unit.
// Holds sizing constants, payload and control structs, and the window length clamp.
// No dependencies.
package swmm_pkg;

    localparam int WINDOW_MAX = 256;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 9;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int POS_W      = $clog2(2 * WINDOW_MAX);

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     stream_start;
    } swmm_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] window_min;
        logic signed [DATA_W-1:0] window_max;
    } swmm_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the incoming sample
        logic clear;       // empty both queues, zero position and fill count
        logic drop_front;  // drop front entry if it has aged out
        logic trim_back;   // drop back entry if the sample dominates it
        logic push;        // append sample, advance position and fill count
    } swmm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic dominated;   // either queue still has a dominated back entry
        logic result_due;  // window is full
    } swmm_stat_t;

    // Per-queue status
    typedef struct packed {
        logic expired;
        logic dominated;
    } swmm_dq_stat_t;

    // Zero acts as one, anything above WINDOW_MAX saturates.
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] w);
        logic [CNT_W-1:0] r;
        if (w == '0) begin
            r = CNT_W'(1);
        end else if (32'(w) > WINDOW_MAX) begin
            r = CNT_W'(WINDOW_MAX);
        end else begin
            r = CNT_W'(w);
        end
        return r;
    endfunction

endpackage

>>> src/swmm_deque.sv
// One monotonic queue of (value, position) held as a circular buffer in a RAM.
// Depends on swmm_pkg.
module swmm_deque (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  swmm_pkg::swmm_cmd_t              cmd,
    input  logic                             max_mode,
    input  logic signed [swmm_pkg::DATA_W-1:0] sample,
    input  logic [swmm_pkg::POS_W-1:0]       position,
    input  logic [swmm_pkg::CNT_W-1:0]       win_len,
    output swmm_pkg::swmm_dq_stat_t          stat,
    output logic signed [swmm_pkg::DATA_W-1:0] front_value
);
    import swmm_pkg::*;

    localparam int ENT_W = DATA_W + POS_W;

    logic [ENT_W-1:0]  mem [WINDOW_MAX];
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ENT_W-1:0]  front_q, back_q;
    logic [ADDR_W-1:0] front_rd, back_rd, tail_addr;
    logic              we;
    logic [ENT_W-1:0]  wdata;
    logic              nonempty;
    logic [POS_W-1:0]  front_age;
    logic signed [DATA_W-1:0] back_value;

    assign tail_addr = head_reg + ADDR_W'(count_reg);
    assign nonempty  = (count_reg != '0);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next  = '0;
            count_next = '0;
        end else if (cmd.drop_front && stat.expired) begin
            head_next  = head_reg + ADDR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.trim_back && stat.dominated) begin
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Read ports follow the next pointers so the registered data always
    // matches the current front and back.
    assign front_rd = head_next;
    assign back_rd  = head_next + ADDR_W'(count_next) - ADDR_W'(1);
    assign we       = cmd.push && !cmd.clear;
    assign wdata    = {sample, position};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[tail_addr] <= wdata;
        end
        front_q <= (we && tail_addr == front_rd) ? wdata : mem[front_rd];
        back_q  <= (we && tail_addr == back_rd) ? wdata : mem[back_rd];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign front_age   = position - front_q[POS_W-1:0];
    assign back_value  = back_q[ENT_W-1:POS_W];
    assign front_value = front_q[ENT_W-1:POS_W];

    assign stat.expired   = nonempty && (front_age >= POS_W'(win_len));
    assign stat.dominated = nonempty &&
                            (max_mode ? (back_value < sample) : (back_value > sample));

endmodule

>>> src/swmm_dpath.sv
// Datapath: sample register, position and fill counters, min and max queues.
// Depends on swmm_pkg and swmm_deque.
module swmm_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  swmm_pkg::swmm_cmd_t               cmd,
    input  logic signed [swmm_pkg::DATA_W-1:0] s_sample,
    input  logic [swmm_pkg::CNT_W-1:0]        win_len,
    output swmm_pkg::swmm_stat_t              stat,
    output swmm_pkg::swmm_out_t               result
);
    import swmm_pkg::*;

    logic signed [DATA_W-1:0] sample_reg;
    logic [POS_W-1:0]         position_reg, position_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    swmm_dq_stat_t            min_stat, max_stat;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_sample;
        end
    end

    always_comb begin
        position_next = position_reg;
        fill_next     = fill_reg;
        if (cmd.clear) begin
            position_next = '0;
            fill_next     = '0;
        end else if (cmd.push) begin
            position_next = position_reg + POS_W'(1);
            if (fill_reg != CNT_W'(WINDOW_MAX)) begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            fill_reg     <= '0;
        end else begin
            position_reg <= position_next;
            fill_reg     <= fill_next;
        end
    end

    swmm_deque u_min_q (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .max_mode    (1'b0),
        .sample      (sample_reg),
        .position    (position_reg),
        .win_len     (win_len),
        .stat        (min_stat),
        .front_value (result.window_min)
    );

    swmm_deque u_max_q (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .max_mode    (1'b1),
        .sample      (sample_reg),
        .position    (position_reg),
        .win_len     (win_len),
        .stat        (max_stat),
        .front_value (result.window_max)
    );

    // expired only steers the queues themselves
    assign stat.dominated  = min_stat.dominated || max_stat.dominated;
    assign stat.result_due = (fill_reg >= win_len);

endmodule

>>> src/swmm_ctrl.sv
// Controller FSM: sequences front drop, back pops, push and result hand-off.
// Depends on swmm_pkg.
module swmm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_start,
    input  logic                 cfg_we,
    input  swmm_pkg::swmm_stat_t stat,
    input  logic                 out_free,
    output logic                 s_ready,
    output logic                 load_out,
    output swmm_pkg::swmm_cmd_t  cmd
);
    import swmm_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DROP   = 2'd1;
    localparam logic [1:0] ST_POP    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.clear = cfg_we || (s_valid && s_start);
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DROP;
                end
            end
            ST_DROP: begin
                cmd.drop_front = 1'b1;
                state_next     = ST_POP;
            end
            ST_POP: begin
                if (stat.dominated) begin
                    cmd.trim_back = 1'b1;
                end else begin
                    cmd.push   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!stat.result_due) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/sliding_window_min_max_unit.sv
// Top level of the sliding window min/max unit.
// Depends on swmm_pkg, swmm_ctrl and swmm_dpath.
//
// Usage:
//   s_valid/s_ready/s_data carry one sample per transaction; setting
//   stream_start restarts the stream (queues and counters cleared) before
//   that sample is taken.
//   m_valid/m_ready/m_data carry {window_min, window_max} of the last
//   window_len samples. No result comes out until window_len samples have
//   arrived since the last restart.
//   cfg_we/cfg_wdata write window_len (0 acts as 1, above 256 saturates);
//   a write also restarts the stream. Write only while the unit is idle.
// Sequencing:
//   Each sample is taken in idle; the controller then drops an aged-out front
//   entry, walks the queue RAMs popping dominated back entries one entry a
//   cycle (both queues share these pop steps, each popping only while its own
//   back entry is dominated), pushes the sample and hands off the result.
//   Each sample is popped at most once from each queue. s_ready stays low
//   until the controller is back in idle.
// Reset: aresetn low clears queues, counters and m_valid; window_len = 1.
// Stall: the result sits in the output register while m_ready is low; the
//   next sample is still taken and worked, and only its result waits, with
//   s_ready low until the output register frees up.
module sliding_window_min_max_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  swmm_pkg::swmm_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output swmm_pkg::swmm_out_t         m_data,
    input  logic                        cfg_we,
    input  logic [swmm_pkg::LEN_W-1:0]  cfg_wdata
);
    import swmm_pkg::*;

    logic [LEN_W-1:0] window_len_reg;
    logic [CNT_W-1:0] win_len;
    logic             m_valid_reg;
    swmm_out_t        m_data_reg;
    swmm_out_t        result;
    swmm_cmd_t        cmd;
    swmm_stat_t       stat;
    logic             load_out;
    logic             out_free;

    // Window length register, reset to one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= LEN_W'(1);
        end else if (cfg_we) begin
            window_len_reg <= cfg_wdata;
        end
    end

    assign win_len = eff_len(window_len_reg);

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    swmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_start  (s_data.stream_start),
        .cfg_we   (cfg_we),
        .stat     (stat),
        .out_free (out_free),
        .s_ready  (s_ready),
        .load_out (load_out),
        .cmd      (cmd)
    );

    swmm_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_sample (s_data.sample),
        .win_len  (win_len),
        .stat     (stat),
        .result   (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
